// ===== rtl/rwge_pkg.sv =====
// rwge_pkg: shared types, constants and helpers for the regular wave grid evaluator.
// Used by rwge_phase, rwge_cordic_cell, rwge_scale and regular_wave_grid_evaluator.
// Depends on nothing.
package rwge_pkg;

    // Widths of the CORDIC data path (Q1.30 with guard bits)
    localparam int CW           = 33;
    localparam int PHASE_W      = 32;
    localparam int GAIN_W       = 24;
    localparam int ELEV_W       = 25;
    localparam int SLOPE_W      = 24;
    localparam int PROD_W       = GAIN_W + 1 + CW;
    localparam int FRAC_SHIFT   = 30;
    localparam int ROUND_W      = PROD_W - FRAC_SHIFT;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Default parameter values
    localparam int DEF_GRID_X       = 256;
    localparam int DEF_GRID_Y       = 256;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES     = 24;

    // 1/K in Q1.30
    localparam logic signed [CW-1:0] CORDIC_INV_GAIN = CW'(652032874);

    // Rounding constant, one half in Q1.30
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd536870912);

    // Saturation limits
    localparam logic signed [ROUND_W-1:0] ELEV_MAX  = ROUND_W'(16777215);
    localparam logic signed [ROUND_W-1:0] ELEV_MIN  = -ROUND_W'(16777215);
    localparam logic signed [ROUND_W-1:0] SLOPE_MAX = ROUND_W'(8388607);
    localparam logic signed [ROUND_W-1:0] SLOPE_MIN = -ROUND_W'(8388608);

    // atan(2^-i) in turns scaled by 2^32
    localparam logic [29:0] ATAN_TURNS [0:ATAN_ENTRIES-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP_X  = 3'd0,
        REG_PHASE_STEP_Y  = 3'd1,
        REG_PHASE_OFFSET  = 3'd2,
        REG_AMPLITUDE     = 3'd3,
        REG_SLOPE_GAIN_X  = 3'd4,
        REG_SLOPE_GAIN_Y  = 3'd5,
        REG_PRESSURE_GAIN = 3'd6
    } t_reg_idx;

    // Quadrant of the phase, top two bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Data handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        t_quad                quad;
    } t_cordic_data;

    // Gains applied after the rotation
    typedef struct packed {
        logic [GAIN_W-1:0]        amplitude;
        logic signed [GAIN_W-1:0] slope_gain_x;
        logic signed [GAIN_W-1:0] slope_gain_y;
        logic [GAIN_W-1:0]        pressure_gain;
    } t_gains;

    // Clamp a rounded product to the elevation range
    function automatic logic signed [ELEV_W-1:0] sat_elev(input logic signed [ROUND_W-1:0] p);
        logic signed [ROUND_W-1:0] c;
        c = p;
        if (p > ELEV_MAX) begin
            c = ELEV_MAX;
        end else if (p < ELEV_MIN) begin
            c = ELEV_MIN;
        end
        return c[ELEV_W-1:0];
    endfunction

    // Clamp a rounded product to the slope range
    function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [ROUND_W-1:0] p);
        logic signed [ROUND_W-1:0] c;
        c = p;
        if (p > SLOPE_MAX) begin
            c = SLOPE_MAX;
        end else if (p < SLOPE_MIN) begin
            c = SLOPE_MIN;
        end
        return c[SLOPE_W-1:0];
    endfunction

endpackage

// ===== rtl/regular_wave_grid_evaluator.sv =====
// regular_wave_grid_evaluator: top level, configuration registers and the evaluation pipe.
// Depends on rwge_pkg, rwge_phase, rwge_cordic_cell and rwge_scale.
//
//   channel   handshake            payload
//   input     i_valid / o_ready    i_x_index, i_y_index
//   result    o_valid / i_ready    o_elevation, o_slope_x, o_slope_y, o_pressure
//   config    i_cfg_we             i_cfg_index, i_cfg_data
//
// One grid point enters per clock while no stall holds the pipe; the result passes through
// the phase front end, the chain of rotation cells and the scale stages, in that order.
// Every stage has its own valid bit, so gaps close up behind a stalled output.
// Reset is synchronous and active low; it empties the pipe and loads register defaults.
// Configuration writes act at once; the user must keep them to an empty pipe (unenforced).
module regular_wave_grid_evaluator
    import rwge_pkg::*;
#(
    parameter int GRID_X       = DEF_GRID_X,
    parameter int GRID_Y       = DEF_GRID_Y,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_x_index,
    input  logic [7:0]                i_y_index,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ELEV_W-1:0]  o_elevation,
    output logic signed [SLOPE_W-1:0] o_slope_x,
    output logic signed [SLOPE_W-1:0] o_slope_y,
    output logic signed [ELEV_W-1:0]  o_pressure,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic [PHASE_W-1:0] r_step_x;
    logic [PHASE_W-1:0] r_step_y;
    logic [PHASE_W-1:0] r_offset;
    t_gains             r_gains;

    logic               w_v   [0:NSTEPS];
    logic               w_rdy [0:NSTEPS];
    t_cordic_data       w_cd  [0:NSTEPS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x              <= '0;
            r_step_y              <= '0;
            r_offset              <= '0;
            r_gains.amplitude     <= GAIN_W'(65536);
            r_gains.slope_gain_x  <= '0;
            r_gains.slope_gain_y  <= '0;
            r_gains.pressure_gain <= GAIN_W'(65536);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PHASE_STEP_X:  r_step_x              <= i_cfg_data;
                REG_PHASE_STEP_Y:  r_step_y              <= i_cfg_data;
                REG_PHASE_OFFSET:  r_offset              <= i_cfg_data;
                REG_AMPLITUDE:     r_gains.amplitude     <= i_cfg_data[GAIN_W-1:0];
                REG_SLOPE_GAIN_X:  r_gains.slope_gain_x  <= i_cfg_data[GAIN_W-1:0];
                REG_SLOPE_GAIN_Y:  r_gains.slope_gain_y  <= i_cfg_data[GAIN_W-1:0];
                REG_PRESSURE_GAIN: r_gains.pressure_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase front end
    rwge_phase #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y)
    ) u_phase (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_x_index (i_x_index),
        .i_y_index (i_y_index),
        .i_step_x  (r_step_x),
        .i_step_y  (r_step_y),
        .i_offset  (r_offset),
        .o_valid   (w_v[0]),
        .i_ready   (w_rdy[0]),
        .o_data    (w_cd[0])
    );

    // Chain of rotation cells
    for (genvar k = 0; k < NSTEPS; k++) begin : g_cell
        rwge_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_cd[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_cd[k+1])
        );
    end

    // Quadrant, gains, saturation and output register
    rwge_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[NSTEPS]),
        .o_ready     (w_rdy[NSTEPS]),
        .i_data      (w_cd[NSTEPS]),
        .i_gains     (r_gains),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_elevation (o_elevation),
        .o_slope_x   (o_slope_x),
        .o_slope_y   (o_slope_y),
        .o_pressure  (o_pressure)
    );

`ifndef SYNTHESIS
    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Elevation and pressure saturate symmetrically
    a_elev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elevation != -ELEV_W'(16777216)) && (o_pressure != -ELEV_W'(16777216)))
        else $error("elevation or pressure outside symmetric range");

    // Zero amplitude gives a flat surface
    a_zero_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_gains.amplitude == '0) |-> (o_elevation == '0))
        else $error("non-zero elevation with zero amplitude");

    // An empty front end always takes a new point
    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_v[0] && !w_v[1]) |-> o_ready)
        else $error("input stalled with free front stages");
`endif

endmodule

// ===== rtl/rwge_phase.sv =====
// rwge_phase: two-stage phase front end, index offset times step, then sum minus offset.
// Emits the quadrant and the initial CORDIC vector for the cell chain.
// Depends on rwge_pkg.
module rwge_phase
    import rwge_pkg::*;
#(
    parameter int GRID_X = DEF_GRID_X,
    parameter int GRID_Y = DEF_GRID_Y
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_x_index,
    input  logic [7:0]            i_y_index,
    input  logic [PHASE_W-1:0]    i_step_x,
    input  logic [PHASE_W-1:0]    i_step_y,
    input  logic [PHASE_W-1:0]    i_offset,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_cordic_data          o_data
);

    localparam logic [PHASE_W-1:0] HALF_X = PHASE_W'(GRID_X / 2);
    localparam logic [PHASE_W-1:0] HALF_Y = PHASE_W'(GRID_Y / 2);

    logic               r_v1;
    logic               r_v2;
    logic [PHASE_W-1:0] r_px;
    logic [PHASE_W-1:0] r_py;
    logic [PHASE_W-1:0] w_dx;
    logic [PHASE_W-1:0] w_dy;
    logic [PHASE_W-1:0] w_phase;
    logic               w_rdy1;
    logic               w_rdy2;
    t_cordic_data       r_data;
    t_cordic_data       n_data;

    // Stage readiness: a stage loads when empty or draining
    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Centred indexes, wrapping modulo 2^32
    assign w_dx = PHASE_W'(i_x_index) - HALF_X;
    assign w_dy = PHASE_W'(i_y_index) - HALF_Y;

    // Phase and initial vector
    assign w_phase     = r_px + r_py - i_offset;
    assign n_data.x    = CORDIC_INV_GAIN;
    assign n_data.y    = '0;
    assign n_data.z    = CW'(w_phase[29:0]);
    assign n_data.quad = t_quad'(w_phase[31:30]);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload: products, then phase
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_px <= PHASE_W'(w_dx * i_step_x);
            r_py <= PHASE_W'(w_dy * i_step_y);
        end
        if (w_rdy2 && r_v1) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_data;

endmodule

// ===== rtl/rwge_cordic_cell.sv =====
// rwge_cordic_cell: one registered CORDIC rotation step with its own valid bit.
// Shift and arctangent are fixed by the STEP parameter.
// Depends on rwge_pkg.
module rwge_cordic_cell
    import rwge_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  t_cordic_data i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output t_cordic_data o_data
);

    localparam logic signed [CW-1:0] ATAN = CW'(ATAN_TURNS[STEP]);

    logic                 r_v;
    logic                 w_rdy;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    t_cordic_data         r_data;
    t_cordic_data         n_data;

    assign w_rdy   = !r_v || i_ready;
    assign o_ready = w_rdy;

    // Rotate towards zero residual angle; shifts floor
    always_comb begin
        w_xs        = i_data.x >>> STEP;
        w_ys        = i_data.y >>> STEP;
        n_data.quad = i_data.quad;
        if (!i_data.z[CW-1]) begin
            n_data.x = i_data.x - w_ys;
            n_data.y = i_data.y + w_xs;
            n_data.z = i_data.z - ATAN;
        end else begin
            n_data.x = i_data.x + w_ys;
            n_data.y = i_data.y - w_xs;
            n_data.z = i_data.z + ATAN;
        end
    end

    // Hold valid until the next cell takes the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

// ===== rtl/rwge_scale.sv =====
// rwge_scale: quadrant fold-out, gain products with rounding, then saturation.
// Three registered stages; the last is the output register.
// Depends on rwge_pkg.
module rwge_scale
    import rwge_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_cordic_data              i_data,
    input  t_gains                    i_gains,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ELEV_W-1:0]  o_elevation,
    output logic signed [SLOPE_W-1:0] o_slope_x,
    output logic signed [SLOPE_W-1:0] o_slope_y,
    output logic signed [ELEV_W-1:0]  o_pressure
);

    logic                       r_va;
    logic                       r_vb;
    logic                       r_vc;
    logic                       w_rdya;
    logic                       w_rdyb;
    logic                       w_rdyc;
    logic signed [CW-1:0]       n_cos;
    logic signed [CW-1:0]       n_sin;
    logic signed [CW-1:0]       r_cos;
    logic signed [CW-1:0]       r_sin;
    logic signed [GAIN_W:0]     w_g_amp;
    logic signed [GAIN_W:0]     w_g_sx;
    logic signed [GAIN_W:0]     w_g_sy;
    logic signed [GAIN_W:0]     w_g_pr;
    logic signed [PROD_W-1:0]   w_m_amp;
    logic signed [PROD_W-1:0]   w_m_sx;
    logic signed [PROD_W-1:0]   w_m_sy;
    logic signed [PROD_W-1:0]   w_m_pr;
    logic signed [ROUND_W-1:0]  r_p_amp;
    logic signed [ROUND_W-1:0]  r_p_sx;
    logic signed [ROUND_W-1:0]  r_p_sy;
    logic signed [ROUND_W-1:0]  r_p_pr;
    logic signed [ELEV_W-1:0]   r_elev;
    logic signed [SLOPE_W-1:0]  r_sx;
    logic signed [SLOPE_W-1:0]  r_sy;
    logic signed [ELEV_W-1:0]   r_pres;

    assign w_rdyc  = !r_vc || i_ready;
    assign w_rdyb  = !r_vb || w_rdyc;
    assign w_rdya  = !r_va || w_rdyb;
    assign o_ready = w_rdya;

    // Fold the first-quadrant result out to the full circle
    always_comb begin
        case (i_data.quad)
            QUAD_0: begin
                n_cos = i_data.x;
                n_sin = i_data.y;
            end
            QUAD_1: begin
                n_cos = -i_data.y;
                n_sin = i_data.x;
            end
            QUAD_2: begin
                n_cos = -i_data.x;
                n_sin = -i_data.y;
            end
            QUAD_3: begin
                n_cos = i_data.y;
                n_sin = -i_data.x;
            end
            default: begin
                n_cos = i_data.x;
                n_sin = i_data.y;
            end
        endcase
    end

    // Gains as signed operands
    assign w_g_amp = $signed({1'b0, i_gains.amplitude});
    assign w_g_sx  = {i_gains.slope_gain_x[GAIN_W-1], i_gains.slope_gain_x};
    assign w_g_sy  = {i_gains.slope_gain_y[GAIN_W-1], i_gains.slope_gain_y};
    assign w_g_pr  = $signed({1'b0, i_gains.pressure_gain});

    // Products rounded to Q8.16, shift floors
    assign w_m_amp = PROD_W'(w_g_amp * r_cos) + ROUND_HALF;
    assign w_m_sx  = PROD_W'(w_g_sx * r_sin) + ROUND_HALF;
    assign w_m_sy  = PROD_W'(w_g_sy * r_sin) + ROUND_HALF;
    assign w_m_pr  = PROD_W'(w_g_pr * r_cos) + ROUND_HALF;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_rdya) begin
                r_va <= i_valid;
            end
            if (w_rdyb) begin
                r_vb <= r_va;
            end
            if (w_rdyc) begin
                r_vc <= r_vb;
            end
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (w_rdya && i_valid) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
        if (w_rdyb && r_va) begin
            r_p_amp <= ROUND_W'(w_m_amp >>> FRAC_SHIFT);
            r_p_sx  <= ROUND_W'(w_m_sx >>> FRAC_SHIFT);
            r_p_sy  <= ROUND_W'(w_m_sy >>> FRAC_SHIFT);
            r_p_pr  <= ROUND_W'(w_m_pr >>> FRAC_SHIFT);
        end
        if (w_rdyc && r_vb) begin
            r_elev <= sat_elev(r_p_amp);
            r_sx   <= sat_slope(r_p_sx);
            r_sy   <= sat_slope(r_p_sy);
            r_pres <= sat_elev(r_p_pr);
        end
    end

    assign o_valid     = r_vc;
    assign o_elevation = r_elev;
    assign o_slope_x   = r_sx;
    assign o_slope_y   = r_sy;
    assign o_pressure  = r_pres;

endmodule

// ===== tb/sv/rwge_wave_check.sv =====
// rwge_wave_check: watches the point and result channels of the wave grid evaluator,
// predicts elevation, slopes and pressure for each accepted point and compares them.
// Depends on rwge_pkg for widths, register indexes and the quadrant type.
`timescale 1ns / 100ps

module rwge_wave_check
    import rwge_pkg::*;
#(
    parameter int GRID_X       = DEF_GRID_X,
    parameter int GRID_Y       = DEF_GRID_Y,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      o_ready,
    input  logic [7:0]                i_x_index,
    input  logic [7:0]                i_y_index,
    input  logic                      o_valid,
    input  logic                      i_ready,
    input  logic signed [ELEV_W-1:0]  o_elevation,
    input  logic signed [SLOPE_W-1:0] o_slope_x,
    input  logic signed [SLOPE_W-1:0] o_slope_y,
    input  logic signed [ELEV_W-1:0]  o_pressure,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_outstanding
);

    localparam int     ROT_STEPS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam longint START_MAG  = 652032874;
    localparam longint HEIGHT_LIM = 16777215;
    localparam longint GRAD_HI    = 8388607;
    localparam longint GRAD_LO    = -8388608;

    // Rotation angles atan(2^-k), turns scaled by 2^32
    localparam longint ROT_ANGLE [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [ELEV_W-1:0]  elevation;
        logic signed [SLOPE_W-1:0] slope_x;
        logic signed [SLOPE_W-1:0] slope_y;
        logic signed [ELEV_W-1:0]  pressure;
    } t_wave_point;

    // Mirror of the block's registers
    logic [31:0]         step_x;
    logic [31:0]         step_y;
    logic [31:0]         time_turns;
    logic [23:0]         height_gain;
    logic signed [23:0]  grad_gain_x;
    logic signed [23:0]  grad_gain_y;
    logic [23:0]         head_gain;

    t_wave_point pending_points[$];
    int          errors;

    // Round a Q8.16 by Q1.30 product back to Q8.16 and clamp it
    function automatic longint scale_clamp(input longint gain, input longint trig,
                                           input longint lo, input longint hi);
        longint p;
        p = (gain * trig + 64'sd536870912) >>> 30;
        if (p > hi) begin
            return hi;
        end
        if (p < lo) begin
            return lo;
        end
        return p;
    endfunction

    function automatic t_wave_point predict_point(input logic [7:0] xi, input logic [7:0] yi);
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] phase;
        longint      re;
        longint      im;
        longint      ang;
        longint      re_sh;
        longint      im_sh;
        longint      cos_v;
        longint      sin_v;
        t_wave_point r;
        dx    = 32'(xi) - 32'(GRID_X / 2);
        dy    = 32'(yi) - 32'(GRID_Y / 2);
        phase = dx * step_x + dy * step_y - time_turns;
        re    = START_MAG;
        im    = 0;
        ang   = {34'd0, phase[29:0]};
        // Rotate towards the residual angle within the first quadrant
        for (int k = 0; k < ROT_STEPS; k++) begin
            re_sh = re >>> k;
            im_sh = im >>> k;
            if (ang >= 0) begin
                re  = re - im_sh;
                im  = im + re_sh;
                ang = ang - ROT_ANGLE[k];
            end else begin
                re  = re + im_sh;
                im  = im - re_sh;
                ang = ang + ROT_ANGLE[k];
            end
        end
        // Fold the result out to the phase's quadrant
        case (t_quad'(phase[31:30]))
            QUAD_0: begin cos_v = re;  sin_v = im;  end
            QUAD_1: begin cos_v = -im; sin_v = re;  end
            QUAD_2: begin cos_v = -re; sin_v = -im; end
            default: begin cos_v = im; sin_v = -re; end
        endcase
        r.elevation = ELEV_W'(scale_clamp({40'd0, height_gain}, cos_v, -HEIGHT_LIM, HEIGHT_LIM));
        r.slope_x   = SLOPE_W'(scale_clamp(longint'(grad_gain_x), sin_v, GRAD_LO, GRAD_HI));
        r.slope_y   = SLOPE_W'(scale_clamp(longint'(grad_gain_y), sin_v, GRAD_LO, GRAD_HI));
        r.pressure  = ELEV_W'(scale_clamp({40'd0, head_gain}, cos_v, -HEIGHT_LIM, HEIGHT_LIM));
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Predict on each point transaction, compare on each result transaction
    always @(posedge i_clk) begin : watch
        t_wave_point want;
        t_wave_point got;
        if (!i_rst_n) begin
            pending_points.delete();
            step_x      = '0;
            step_y      = '0;
            time_turns  = '0;
            height_gain = 24'd65536;
            grad_gain_x = '0;
            grad_gain_y = '0;
            head_gain   = 24'd65536;
        end else begin
            if (i_valid && o_ready) begin
                pending_points.push_back(predict_point(i_x_index, i_y_index));
            end
            if (o_valid && i_ready) begin
                got = '{o_elevation, o_slope_x, o_slope_y, o_pressure};
                if (pending_points.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %0d",
                             $time, o_elevation);
                    errors++;
                end else begin
                    want = pending_points.pop_front();
                    check_field("elevation", want.elevation, got.elevation);
                    check_field("slope_x", want.slope_x, got.slope_x);
                    check_field("slope_y", want.slope_y, got.slope_y);
                    check_field("pressure", want.pressure, got.pressure);
                end
            end
            // Apply register writes after predicting, as the block does
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PHASE_STEP_X:  step_x      = i_cfg_data;
                    REG_PHASE_STEP_Y:  step_y      = i_cfg_data;
                    REG_PHASE_OFFSET:  time_turns  = i_cfg_data;
                    REG_AMPLITUDE:     height_gain = i_cfg_data[23:0];
                    REG_SLOPE_GAIN_X:  grad_gain_x = i_cfg_data[23:0];
                    REG_SLOPE_GAIN_Y:  grad_gain_y = i_cfg_data[23:0];
                    REG_PRESSURE_GAIN: head_gain   = i_cfg_data[23:0];
                    default: ;
                endcase
            end
        end
        o_outstanding <= pending_points.size();
        o_fail_count  <= errors;
    end

endmodule

// ===== tb/sv/regular_wave_grid_evaluator_test.sv =====
// regular_wave_grid_evaluator_test: drives grid points and register settings into the
// wave grid evaluator with random gaps and stalls; rwge_wave_check does the checking.
// Depends on rwge_pkg, regular_wave_grid_evaluator and rwge_wave_check.
`timescale 1ns / 100ps

module regular_wave_grid_evaluator_test;
    import rwge_pkg::*;

    localparam int ITEMS_PER_PHASE = 240;
    localparam int RANDOM_PHASES   = 8;
    localparam int LONG_HOLD       = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [7:0]                i_x_index;
    logic [7:0]                i_y_index;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [ELEV_W-1:0]  o_elevation;
    logic signed [SLOPE_W-1:0] o_slope_x;
    logic signed [SLOPE_W-1:0] o_slope_y;
    logic signed [ELEV_W-1:0]  o_pressure;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;

    int fail_count;
    int outstanding;
    bit no_idle;
    int hold_requests;
    int holds_done;

    regular_wave_grid_evaluator dut (.*);

    rwge_wave_check u_wave_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_x_index     (i_x_index),
        .i_y_index     (i_y_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_elevation   (o_elevation),
        .o_slope_x     (o_slope_x),
        .o_slope_y     (o_slope_y),
        .o_pressure    (o_pressure),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("regular_wave_grid_evaluator_test failed");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        if (no_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3, 4: return $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0080_0000;
            3: return 32'h007F_FFFF;
            4: return 32'h0001_0000;
            5: return 32'hFF00_0001;
            default: return $urandom();
        endcase
    endfunction

    // Result side: random stalls, plus a long hold-off whenever one is requested
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_requests) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
                gap = gap_len();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one grid point and hold it until the transaction completes
    task automatic send_point(input logic [7:0] xi, input logic [7:0] yi);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_index <= xi;
        i_y_index <= yi;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Write enable is left high; the caller drops it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_random_settings();
        cfg_write(REG_PHASE_STEP_X, pick_step());
        cfg_write(REG_PHASE_STEP_Y, pick_step());
        cfg_write(REG_PHASE_OFFSET, $urandom());
        cfg_write(REG_AMPLITUDE, pick_gain());
        cfg_write(REG_SLOPE_GAIN_X, pick_gain());
        cfg_write(REG_SLOPE_GAIN_Y, pick_gain());
        cfg_write(REG_PRESSURE_GAIN, pick_gain());
        if ($urandom_range(0, 2) == 0) begin
            cfg_write(REG_UNUSED, $urandom());
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] sx;
        logic [7:0] sy;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_x_index     <= '0;
        i_y_index     <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        no_idle       = 1'b0;
        hold_requests = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: field extremes and alternating bit patterns
        send_point(8'd0, 8'd0);
        send_point(8'd255, 8'd255);
        send_point(8'd128, 8'd128);
        send_point(8'h55, 8'hAA);
        send_point(8'hAA, 8'h55);
        drain();

        // One turn across x, extreme gains, oversized writes and an unused index
        cfg_write(REG_PHASE_STEP_X, 32'h0100_0000);
        cfg_write(REG_PHASE_STEP_Y, 32'h0001_0000);
        cfg_write(REG_PHASE_OFFSET, 32'h0000_0000);
        cfg_write(REG_AMPLITUDE, 32'hABFF_FFFF);
        cfg_write(REG_SLOPE_GAIN_X, 32'h0080_0000);
        cfg_write(REG_SLOPE_GAIN_Y, 32'h5A7F_FFFF);
        cfg_write(REG_PRESSURE_GAIN, 32'h0000_0000);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 8; k++) begin
            send_point(8'(k * 32), 8'd128);
        end
        send_point(8'd255, 8'd128);
        send_point(8'd128, 8'd0);
        send_point(8'd128, 8'd255);
        send_point(8'd64, 8'd192);
        drain();

        // Quarter turn per row with an eighth-turn offset, so each row lands mid-quadrant
        cfg_write(REG_PHASE_STEP_X, 32'h0000_0000);
        cfg_write(REG_PHASE_STEP_Y, 32'h4000_0000);
        cfg_write(REG_PHASE_OFFSET, 32'h2000_0000);
        cfg_write(REG_AMPLITUDE, 32'h0000_0000);
        cfg_write(REG_SLOPE_GAIN_X, 32'h007F_FFFF);
        cfg_write(REG_SLOPE_GAIN_Y, 32'hFF80_0000);
        cfg_write(REG_PRESSURE_GAIN, 32'h00FF_FFFF);
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 4; k++) begin
            send_point(8'd0, 8'(k));
        end
        send_point(8'd0, 8'd255);
        drain();

        // Random settings per phase; odd phases scan rows like a field refresh
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_random_settings();
            no_idle = (p == 3);
            sx = 8'($urandom());
            sy = 8'($urandom());
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ((p == 2 || p == 5) && n == 40) begin
                    hold_requests++;
                end
                if (p == 4 && n == 120) begin
                    drain();
                end
                if (p % 2 == 1) begin
                    send_point(sx, sy);
                    sx = sx + 8'd1;
                    if (sx == 8'd0) begin
                        sy = sy + 8'd1;
                    end
                end else begin
                    send_point(8'($urandom()), 8'($urandom()));
                end
            end
            drain();
        end
        no_idle = 1'b0;

        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("regular_wave_grid_evaluator_test passed");
        end else begin
            $display("regular_wave_grid_evaluator_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rwge_pkg.sv
rtl/rwge_phase.sv
rtl/rwge_cordic_cell.sv
rtl/rwge_scale.sv
rtl/regular_wave_grid_evaluator.sv
tb/sv/rwge_wave_check.sv
tb/sv/regular_wave_grid_evaluator_test.sv
